>>> src/gafs_pkg.sv
// Shared types and constants for the GA fitness scaling unit.
// Used by gafs_lane and ga_fitness_scaling_unit; depends on nothing.
`default_nettype none
package gafs_pkg;

  localparam int POP_MAX_DEF = 64;
  localparam int OBJ_MAX_DEF = 4;
  localparam int OBJ_W       = 32;
  localparam int WEIGHT_W    = 16;
  localparam int FIT_W       = 18;
  localparam int SW_W        = 17;
  localparam int NOBJ_W      = 3;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int NUM_OBJ_IN  = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUM_OBJ = 3'd0,
    CFG_W0      = 3'd1,
    CFG_W1      = 3'd2,
    CFG_W2      = 3'd3,
    CFG_W3      = 3'd4
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SC_START,
    ST_SC_WAIT,
    ST_EM_READ,
    ST_EM_DIV,
    ST_EM_WAIT,
    ST_EM_PUT
  } state_t;

  typedef struct packed {
    logic signed [OBJ_W-1:0] objective_a;
    logic signed [OBJ_W-1:0] objective_b;
    logic signed [OBJ_W-1:0] objective_c;
    logic signed [OBJ_W-1:0] objective_d;
    logic                    final_individual;
  } in_t;

  typedef struct packed {
    logic [FIT_W-1:0] fitness_value;
    logic [SW_W-1:0]  selection_weight;
    logic             zero_total;
    logic             last_result;
  } out_t;

  // load control from the sequencer to each lane
  typedef struct packed {
    logic we;
    logic first;
  } lane_ld_t;

endpackage
`default_nettype wire

>>> src/gafs_div.sv
// Restoring divider, one quotient bit per cycle.
// Requires num >> QW < den. Uses nothing from the package.
`default_nettype none
module gafs_div #(
  parameter int NW = 48,
  parameter int DW = 32,
  parameter int QW = 16
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  output logic               done,
  output logic [QW-1:0]      quot
);
  localparam int CW = $clog2(QW + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [DW-1:0] rem;
  logic [DW:0]   trial;
  logic          ge;

  assign trial = {rem, quot[QW-1]};
  assign ge    = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(QW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= DW'(num >> QW);
      quot <= num[QW-1:0];
    end else if (busy) begin
      rem  <= ge ? DW'(trial - {1'b0, den}) : trial[DW-1:0];
      quot <= {quot[QW-2:0], ge};
    end
  end
endmodule
`default_nettype wire

>>> src/gafs_lane.sv
// One objective lane: value memory, running min/max, weight multiply and scaling divide.
// Depends on gafs_pkg and gafs_div.
`default_nettype none
module gafs_lane #(
  parameter int POP_MAX = gafs_pkg::POP_MAX_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire gafs_pkg::lane_ld_t                ld,
  input  wire logic [$clog2(POP_MAX)-1:0]        ld_idx,
  input  wire logic signed [gafs_pkg::OBJ_W-1:0] ld_value,
  input  wire logic                              start,
  input  wire logic [$clog2(POP_MAX)-1:0]        rd_idx,
  input  wire logic [gafs_pkg::WEIGHT_W-1:0]     weight,
  output logic                                   done,
  output logic [gafs_pkg::WEIGHT_W-1:0]          term
);
  import gafs_pkg::*;

  localparam int PW = WEIGHT_W + OBJ_W;

  logic signed [OBJ_W-1:0] mem [POP_MAX];
  logic signed [OBJ_W-1:0] rd_data;
  logic signed [OBJ_W-1:0] vmin, vmax;
  logic                    p1, p2;
  logic [PW-1:0]           prod;
  logic [OBJ_W-1:0]        span;
  logic signed [OBJ_W:0]   dist_w, span_w;
  logic                    div_done;
  logic [WEIGHT_W-1:0]     quot;

  always_ff @(posedge clk) begin
    if (ld.we) mem[ld_idx] <= ld_value;
    if (start) rd_data <= mem[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (ld.we) begin
      if (ld.first || ld_value < vmin) vmin <= ld_value;
      if (ld.first || ld_value > vmax) vmax <= ld_value;
    end
  end

  assign dist_w = {vmax[OBJ_W-1], vmax} - {rd_data[OBJ_W-1], rd_data};
  assign span_w = {vmax[OBJ_W-1], vmax} - {vmin[OBJ_W-1], vmin};

  always_ff @(posedge clk) begin
    if (rst) begin
      p1 <= 1'b0;
      p2 <= 1'b0;
    end else begin
      p1 <= start;
      p2 <= p1;
    end
  end

  always_ff @(posedge clk) begin
    if (p1) begin
      prod <= PW'(weight) * PW'(dist_w[OBJ_W-1:0]);
      span <= span_w[OBJ_W-1:0];
    end
  end

  gafs_div #(.NW(PW), .DW(OBJ_W), .QW(WEIGHT_W)) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(p2),
    .num  (prod),
    .den  (span),
    .done (div_done),
    .quot (quot)
  );

  assign done = div_done;
  // flat objective scores the full weight
  assign term = (span == '0) ? weight : quot;
endmodule
`default_nettype wire

>>> src/ga_fitness_scaling_unit.sv
// GA fitness scaling unit: loads one individual per cycle while in the load state, then
// scores the population. Load: one transfer per cycle while in_stall is low, no result.
// After the final item, every individual gets the lane multiply plus 16-step divide;
// then each gets the 17-step selection weight divide and an output transfer.
// Reset (rst, synchronous) empties the population and restores default registers.
// Depends on gafs_pkg, gafs_lane, gafs_div.
`default_nettype none
module ga_fitness_scaling_unit #(
  parameter int POP_MAX = gafs_pkg::POP_MAX_DEF,
  parameter int OBJ_MAX = gafs_pkg::OBJ_MAX_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire gafs_pkg::in_t                   in_data,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output gafs_pkg::out_t                       out_data,
  input  wire logic                            cfg_we,
  input  wire logic [gafs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [gafs_pkg::CFG_DATA_W-1:0] cfg_data
);
  import gafs_pkg::*;

  localparam int IW    = $clog2(POP_MAX);
  localparam int CW    = $clog2(POP_MAX + 1);
  localparam int TOT_W = FIT_W + $clog2(POP_MAX);
  localparam int NUMW  = FIT_W + 16;

  state_t state, state_next;

  logic [NOBJ_W-1:0]   num_obj;
  logic [WEIGHT_W-1:0] weight [NUM_OBJ_IN];
  logic [CW-1:0]       count;
  logic [CW-1:0]       idx;
  logic [TOT_W-1:0]    total;
  logic [FIT_W-1:0]    fs [POP_MAX];
  logic [FIT_W-1:0]    fs_rd;

  logic                    accept, store, last_idx;
  logic                    lane_start, wt_start, wt_done, all_done, put;
  lane_ld_t                ld;
  logic signed [OBJ_W-1:0] obj_vec [NUM_OBJ_IN];
  logic [OBJ_MAX-1:0]      lane_done;
  logic [WEIGHT_W-1:0]     term [OBJ_MAX];
  logic [FIT_W-1:0]        fit_sum;
  logic [SW_W-1:0]         wt_quot;

  assign accept   = in_valid && !in_stall;
  assign store    = accept && (count < CW'(POP_MAX));
  assign last_idx = (idx == count - 1'b1);
  assign all_done = &lane_done;
  assign put      = (state == ST_EM_PUT) && (!out_valid || !out_stall);

  assign ld.we    = store;
  assign ld.first = (count == '0);

  always_comb begin
    obj_vec[0] = in_data.objective_a;
    obj_vec[1] = in_data.objective_b;
    obj_vec[2] = in_data.objective_c;
    obj_vec[3] = in_data.objective_d;
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      num_obj   <= NOBJ_W'(2);
      weight[0] <= WEIGHT_W'(4096);
      weight[1] <= WEIGHT_W'(4096);
      weight[2] <= '0;
      weight[3] <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_NUM_OBJ: num_obj   <= cfg_data[NOBJ_W-1:0];
        CFG_W0:      weight[0] <= cfg_data;
        CFG_W1:      weight[1] <= cfg_data;
        CFG_W2:      weight[2] <= cfg_data;
        CFG_W3:      weight[3] <= cfg_data;
        default:     ;
      endcase
    end
  end

  genvar l;
  generate
    for (l = 0; l < OBJ_MAX; l++) begin : g_lane
      gafs_lane #(.POP_MAX(POP_MAX)) u_lane (
        .clk     (clk),
        .rst     (rst),
        .ld      (ld),
        .ld_idx  (count[IW-1:0]),
        .ld_value(obj_vec[l]),
        .start   (lane_start),
        .rd_idx  (idx[IW-1:0]),
        .weight  (weight[l]),
        .done    (lane_done[l]),
        .term    (term[l])
      );
    end
  endgenerate

  // merge: add the terms of the objectives in use
  always_comb begin
    fit_sum = '0;
    for (int o = 0; o < OBJ_MAX; o++) begin
      if (o == 0 || NOBJ_W'(o) < num_obj) fit_sum = fit_sum + FIT_W'(term[o]);
    end
  end

  gafs_div #(.NW(NUMW), .DW(TOT_W), .QW(SW_W)) u_wdiv (
    .clk  (clk),
    .rst  (rst),
    .start(wt_start),
    .num  ({fs_rd, 16'b0}),
    .den  (total),
    .done (wt_done),
    .quot (wt_quot)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_LOAD:     if (accept && in_data.final_individual) state_next = ST_SC_START;
      ST_SC_START: state_next = ST_SC_WAIT;
      ST_SC_WAIT:  if (all_done) state_next = last_idx ? ST_EM_READ : ST_SC_START;
      ST_EM_READ:  state_next = ST_EM_DIV;
      ST_EM_DIV:   state_next = ST_EM_WAIT;
      ST_EM_WAIT:  if (wt_done) state_next = ST_EM_PUT;
      ST_EM_PUT:   if (put) state_next = last_idx ? ST_LOAD : ST_EM_READ;
      default:     state_next = ST_LOAD;
    endcase
  end

  always_comb begin
    in_stall   = (state != ST_LOAD);
    lane_start = (state == ST_SC_START);
    wt_start   = (state == ST_EM_DIV);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_LOAD;
      count     <= '0;
      idx       <= '0;
      total     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= put || (out_valid && out_stall);
      case (state)
        ST_LOAD: begin
          if (store) count <= count + 1'b1;
          if (accept && in_data.final_individual) begin
            idx   <= '0;
            total <= '0;
          end
        end
        ST_SC_WAIT: begin
          if (all_done) begin
            total <= total + TOT_W'(fit_sum);
            idx   <= last_idx ? '0 : idx + 1'b1;
          end
        end
        ST_EM_PUT: begin
          if (put) begin
            idx <= idx + 1'b1;
            if (last_idx) count <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_SC_WAIT && all_done) fs[idx[IW-1:0]] <= fit_sum;
    if (state == ST_EM_READ) fs_rd <= fs[idx[IW-1:0]];
    if (put) begin
      out_data.fitness_value    <= fs_rd;
      out_data.selection_weight <= (total == '0) ? '0 : wt_quot;
      out_data.zero_total       <= (total == '0);
      out_data.last_result      <= last_idx;
    end
  end

  a_final_scores: assert property (@(posedge clk) disable iff (rst)
    accept && in_data.final_individual |=> state == ST_SC_START)
    else $error("final transfer did not start scoring");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(POP_MAX))
    else $error("population count overflow");
  a_wdiv_phase: assert property (@(posedge clk) disable iff (rst)
    wt_done |-> state == ST_EM_WAIT)
    else $error("weight divide finished outside emit wait");
  a_zero_weight: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.zero_total |-> out_data.selection_weight == '0)
    else $error("nonzero weight with zero total");
endmodule
`default_nettype wire
